@@ sv/assert_macros.svh @@
// assertion macros used by the top level of the broadcast index map
// no dependencies; assertions are compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");
// checked at every edge, reset included
`define ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_RST(label, clk, prop)
`endif
`endif

@@ sv/bexp_pkg.sv @@
// shared types and constants of the broadcast index map
// no dependencies
package bexp_pkg;

    localparam int IDX_W = 48;      // width of linear indices
    localparam int DIV_STEPS = 4;   // quotient bits resolved per divider stage

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SHAPE = 2'd2;

    // item as it travels the axis pipeline
    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] quo;      // remaining index, becomes quotient
        logic [IDX_W-1:0] src;      // source index so far
        logic [IDX_W-1:0] stride;   // input stride of current axis
    } bexp_item_t;

endpackage

@@ sv/broadcast_expand_index_map.sv @@
// top level of the broadcast index map: config registers and stage chain
// depends on bexp_pkg, bexp_check, bexp_div, bexp_acc, assert_macros.svh
//
// Maps a row-major output index of a broadcast tensor to the row-major index
// of its source element. One beat is accepted and one result beat leaves per
// cycle while the output is not stalled; the restoring divider resolves four
// quotient bits per stage for each axis. Every stage has its own valid bit and
// ready term, so a stalled output fills bubbles before it holds the input.
// The user writes registers through cfg_we/cfg_index/cfg_data only while the
// pipeline is empty; the block itself does not enforce this. Indices beyond
// the list are ignored.
`include "assert_macros.svh"
module broadcast_expand_index_map import bexp_pkg::*; #(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // register write port
    input  logic                              cfg_we,
    input  logic [$clog2(2*MAX_RANK+1)-1:0]   cfg_index,
    input  logic [DIM_BITS-1:0]               cfg_data,
    // index beats in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [IDX_W-1:0]                  s_out_index,
    // result beats out
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [IDX_W-1:0]                  m_source_index,
    output logic [1:0]                        m_status
);

    localparam int CFG_IDX_W = $clog2(2 * MAX_RANK + 1);
    localparam int DIV_ST = IDX_W / DIV_STEPS;    // divider stages per axis
    localparam int AX_ST = DIV_ST + 1;            // plus accumulate stage
    localparam int NS = MAX_RANK * AX_ST;

    logic [DIM_BITS-1:0] in_dim_reg  [MAX_RANK];
    logic [DIM_BITS-1:0] tgt_dim_reg [MAX_RANK];
    logic [DIM_BITS-1:0] odim        [MAX_RANK];
    logic                shape_bad;

    // stage chain, position 0 is the check output
    logic                cv   [NS+1];
    logic                cr   [NS+1];
    bexp_item_t          ci   [NS+1];
    logic [DIM_BITS-1:0] crem [NS+1];

    // register file, reset to all ones (scalar shapes)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_RANK; k++) begin
                in_dim_reg[k] <= DIM_BITS'(1);
                tgt_dim_reg[k] <= DIM_BITS'(1);
            end
        end else if (cfg_we) begin
            for (int k = 0; k < MAX_RANK; k++) begin
                if (cfg_index == CFG_IDX_W'(k)) begin
                    in_dim_reg[k] <= cfg_data;
                end
                if (cfg_index == CFG_IDX_W'(MAX_RANK + k)) begin
                    tgt_dim_reg[k] <= cfg_data;
                end
            end
        end
    end

    // output shape and compatibility, static while beats are in flight
    always_comb begin
        shape_bad = 1'b0;
        for (int k = 0; k < MAX_RANK; k++) begin
            odim[k] = (in_dim_reg[k] == DIM_BITS'(1)) ? tgt_dim_reg[k] : in_dim_reg[k];
            if (in_dim_reg[k] != tgt_dim_reg[k] && in_dim_reg[k] != DIM_BITS'(1)
                && tgt_dim_reg[k] != DIM_BITS'(1)) begin
                shape_bad = 1'b1;
            end
        end
    end

    bexp_check #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .odim      (odim),
        .shape_bad (shape_bad),
        .in_valid  (s_valid),
        .in_index  (s_out_index),
        .in_ready  (s_ready),
        .out_valid (cv[0]),
        .out_item  (ci[0]),
        .out_ready (cr[0])
    );

    // axes innermost first: divide by the output size, then accumulate
    for (genvar a = 0; a < MAX_RANK; a++) begin : g_axis
        localparam int K = MAX_RANK - 1 - a;
        localparam int B = a * AX_ST;
        // the remainder starts at zero on every axis
        assign crem[B] = '0;
        for (genvar j = 0; j < DIV_ST; j++) begin : g_div
            bexp_div #(
                .DIM_BITS (DIM_BITS)
            ) u_div (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .divisor   (odim[K]),
                .in_valid  (cv[B+j]),
                .in_item   (ci[B+j]),
                .in_rem    (crem[B+j]),
                .in_ready  (cr[B+j]),
                .out_valid (cv[B+j+1]),
                .out_item  (ci[B+j+1]),
                .out_rem   (crem[B+j+1]),
                .out_ready (cr[B+j+1])
            );
        end
        bexp_acc #(
            .DIM_BITS (DIM_BITS)
        ) u_acc (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_dim    (in_dim_reg[K]),
            .in_valid  (cv[B+DIV_ST]),
            .in_item   (ci[B+DIV_ST]),
            .coord     (crem[B+DIV_ST]),
            .in_ready  (cr[B+DIV_ST]),
            .out_valid (cv[B+AX_ST]),
            .out_item  (ci[B+AX_ST]),
            .out_ready (cr[B+AX_ST])
        );
    end

    // final remainder carries no meaning
    assign crem[NS] = '0;
    assign cr[NS] = m_ready;

    assign m_valid = cv[NS];
    assign m_status = ci[NS].status;
    // failed beats report index zero
    assign m_source_index = (ci[NS].status == ST_OK) ? ci[NS].src : '0;

    `ASSERT_CLK(a_fail_zero, aclk, aresetn, m_valid && m_status != ST_OK |-> m_source_index == '0)
    `ASSERT_CLK(a_status_code, aclk, aresetn, m_valid |-> (m_status == ST_OK || m_status == ST_RANGE || m_status == ST_SHAPE))
    `ASSERT_CLK(a_ready_through, aclk, aresetn, m_ready || !m_valid |-> s_ready)
    `ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

@@ sv/bexp_check.sv @@
// shape and range check: element count built one axis per stage
// depends on bexp_pkg
module bexp_check import bexp_pkg::*; #(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [DIM_BITS-1:0] odim [MAX_RANK],
    input  logic                shape_bad,
    input  logic                in_valid,
    input  logic [IDX_W-1:0]    in_index,
    output logic                in_ready,
    output logic                out_valid,
    output bexp_item_t          out_item,
    input  logic                out_ready
);

    localparam int TOT_W = IDX_W + 1;
    localparam int PROD_W = TOT_W + DIM_BITS;
    localparam logic [TOT_W-1:0] CAP = {1'b1, {IDX_W{1'b0}}};

    logic             v_reg   [MAX_RANK];
    logic [IDX_W-1:0] idx_reg [MAX_RANK];
    logic [TOT_W-1:0] tot_reg [MAX_RANK];
    logic             bad_reg [MAX_RANK];
    logic             rdy     [MAX_RANK+1];
    logic             out_v_reg;
    bexp_item_t       item_reg;

    function automatic logic [TOT_W-1:0] sat_mul(input logic [TOT_W-1:0] a,
                                                 input logic [DIM_BITS-1:0] b);
        logic [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        sat_mul = (p > PROD_W'(CAP)) ? CAP : p[TOT_W-1:0];
    endfunction

    assign in_ready = rdy[0];
    assign rdy[MAX_RANK] = !out_v_reg || out_ready;

    for (genvar k = 0; k < MAX_RANK; k++) begin : g_stage
        logic             pv;
        logic [IDX_W-1:0] pidx;
        logic [TOT_W-1:0] tot_next;
        logic             pbad;
        if (k == 0) begin : g_first
            assign pv = in_valid;
            assign pidx = in_index;
            assign pbad = shape_bad;
            assign tot_next = TOT_W'(odim[0]);
        end else begin : g_rest
            assign pv = v_reg[k-1];
            assign pidx = idx_reg[k-1];
            assign pbad = bad_reg[k-1];
            assign tot_next = sat_mul(tot_reg[k-1], odim[k]);
        end
        assign rdy[k] = !v_reg[k] || rdy[k+1];
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= pv;
            end
            if (rdy[k] && pv) begin
                idx_reg[k] <= pidx;
                tot_reg[k] <= tot_next;
                bad_reg[k] <= pbad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (rdy[MAX_RANK]) begin
            out_v_reg <= v_reg[MAX_RANK-1];
        end
        if (rdy[MAX_RANK] && v_reg[MAX_RANK-1]) begin
            if (bad_reg[MAX_RANK-1]) begin
                item_reg.status <= ST_SHAPE;
            end else if (TOT_W'(idx_reg[MAX_RANK-1]) >= tot_reg[MAX_RANK-1]) begin
                item_reg.status <= ST_RANGE;
            end else begin
                item_reg.status <= ST_OK;
            end
            item_reg.quo <= idx_reg[MAX_RANK-1];
            item_reg.src <= '0;
            item_reg.stride <= IDX_W'(1);
        end
    end

    assign out_valid = out_v_reg;
    assign out_item = item_reg;

endmodule

@@ sv/bexp_div.sv @@
// one slice of the restoring divider, DIV_STEPS quotient bits per stage
// depends on bexp_pkg
module bexp_div import bexp_pkg::*; #(
    parameter int DIM_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [DIM_BITS-1:0] divisor,
    input  logic                in_valid,
    input  bexp_item_t          in_item,
    input  logic [DIM_BITS-1:0] in_rem,
    output logic                in_ready,
    output logic                out_valid,
    output bexp_item_t          out_item,
    output logic [DIM_BITS-1:0] out_rem,
    input  logic                out_ready
);

    logic                v_reg;
    bexp_item_t          item_reg;
    logic [DIM_BITS-1:0] rem_reg;
    bexp_item_t          item_next;
    logic [DIM_BITS-1:0] rem_next;

    always_comb begin
        logic [DIM_BITS:0] t;
        item_next = in_item;
        rem_next = in_rem;
        for (int s = 0; s < DIV_STEPS; s++) begin
            t = {rem_next, item_next.quo[IDX_W-1]};
            item_next.quo = {item_next.quo[IDX_W-2:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
                t = t - {1'b0, divisor};
                item_next.quo[0] = 1'b1;
            end
            rem_next = t[DIM_BITS-1:0];
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
            rem_reg <= rem_next;
        end
    end

    assign out_valid = v_reg;
    assign out_item = item_reg;
    assign out_rem = rem_reg;

endmodule

@@ sv/bexp_acc.sv @@
// per-axis accumulate: adds coordinate times stride unless the input size is one, advances the stride
// depends on bexp_pkg
module bexp_acc import bexp_pkg::*; #(
    parameter int DIM_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [DIM_BITS-1:0] in_dim,
    input  logic                in_valid,
    input  bexp_item_t          in_item,
    input  logic [DIM_BITS-1:0] coord,
    output logic                in_ready,
    output logic                out_valid,
    output bexp_item_t          out_item,
    input  logic                out_ready
);

    localparam int PROD_W = IDX_W + DIM_BITS;

    logic              v_reg;
    bexp_item_t        item_reg;
    logic [PROD_W-1:0] cprod;
    logic [PROD_W-1:0] sprod;
    bexp_item_t        item_next;

    assign cprod = PROD_W'(coord) * PROD_W'(in_item.stride);
    assign sprod = PROD_W'(in_dim) * PROD_W'(in_item.stride);

    always_comb begin
        item_next = in_item;
        // axes of input size one add nothing
        if (in_dim > DIM_BITS'(1)) begin
            item_next.src = in_item.src + cprod[IDX_W-1:0];
        end
        item_next.stride = sprod[IDX_W-1:0];
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v_reg;
    assign out_item = item_reg;

endmodule
